### design/dynamic_node_id_client_top_assert.svh
// assertion macros for the allocation client
`ifndef DYNAMIC_NODE_ID_CLIENT_TOP_ASSERT_SVH
`define DYNAMIC_NODE_ID_CLIENT_TOP_ASSERT_SVH

`ifndef SYNTH
`define DNIC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dnic assertion failed");
`define DNIC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("dnic assertion failed");
`else
`define DNIC_ASSERT(lbl, clk, rst, prop)
`define DNIC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/dnic_pkg.sv
package dnic_pkg;

   localparam int UID_BYTES = 16;
   localparam int OUT_BYTES = 6;
   localparam int MAX_CHUNK = 6;
   localparam int MAX_NODE  = 127;
   localparam int CHUNK_LIM = (MAX_CHUNK > OUT_BYTES) ? OUT_BYTES : MAX_CHUNK;

   localparam logic [1:0] CSR_UID_LOW      = 2'd0;
   localparam logic [1:0] CSR_UID_HIGH     = 2'd1;
   localparam logic [1:0] CSR_PREFERRED_ID = 2'd2;

   localparam logic OP_REQUEST  = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [6:0]  resp_node;
      logic [4:0]  resp_len;
      logic [63:0] resp_uid_low;
      logic [63:0] resp_uid_high;
   } req_type;

   typedef struct packed {
      logic        req_valid;
      logic        req_first;
      logic [6:0]  req_prefer;
      logic [2:0]  req_len;
      logic [47:0] req_bytes;
      logic [6:0]  held_id;
      logic [4:0]  echoed;
   } rsp_type;

endpackage

### design/dnic_req_if.sv
interface dnic_req_if;
   logic             valid;
   logic             ready;
   dnic_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/dnic_rsp_if.sv
interface dnic_rsp_if;
   logic             valid;
   logic             ready;
   dnic_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/dynamic_node_id_client_top.sv
// channel   direction  beat
// req_if    in         op, resp_node, resp_len, resp_uid_low, resp_uid_high
// rsp_if    out        req_valid, req_first, req_prefer, req_len, req_bytes, held_id, echoed
// csr_*     in         uid_low, uid_high, preferred_id writes, no read-back
//
// one beat per cycle sustained while rsp_if.ready holds; registered path: input register, then result register
// the chunk shifter and 16-byte echo compare sit between the two registers
// synchronous active-high reset clears valids, held id and echoed length
// a stalled result holds the pipe; req_if.ready drops only when both stages are full
`include "dynamic_node_id_client_top_assert.svh"

module dynamic_node_id_client_top (
   input  logic               clock,
   input  logic               reset,
   dnic_req_if.sink           req_if,
   dnic_rsp_if.source         rsp_if,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   logic [63:0] uid_low_ff;
   logic [63:0] uid_high_ff;
   logic [6:0]  preferred_ff;
   logic [6:0]  allocated_ff;
   logic [6:0]  allocated_in;
   logic [4:0]  prefix_ff;
   logic [4:0]  prefix_in;

   logic              stage_valid_ff;
   dnic_pkg::req_type stage_ff;
   logic              out_valid_ff;
   dnic_pkg::rsp_type out_ff;
   dnic_pkg::rsp_type out_in;

   logic         out_free;
   logic         stage_move;
   logic [127:0] uid_all;
   logic [127:0] echo_all;
   logic [127:0] uid_shift;
   logic [4:0]   remain;
   logic [2:0]   chunk;
   logic [4:0]   echo_n;
   logic         match;
   logic         node_ok;

   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign stage_move   = stage_valid_ff && out_free;
   assign req_if.ready = !stage_valid_ff || out_free;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         uid_low_ff   <= '0;
         uid_high_ff  <= '0;
         preferred_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dnic_pkg::CSR_UID_LOW:      uid_low_ff   <= csr_wdata;
            dnic_pkg::CSR_UID_HIGH:     uid_high_ff  <= csr_wdata;
            dnic_pkg::CSR_PREFERRED_ID: preferred_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // chunk selection
   assign uid_all   = {uid_high_ff, uid_low_ff};
   assign echo_all  = {stage_ff.resp_uid_high, stage_ff.resp_uid_low};
   assign uid_shift = uid_all >> {prefix_ff, 3'b000};
   assign remain    = 5'(dnic_pkg::UID_BYTES) - prefix_ff;
   assign chunk     = (remain > 5'(dnic_pkg::CHUNK_LIM)) ? 3'(dnic_pkg::CHUNK_LIM)
                                                          : remain[2:0];

   // echo compare, bytes past the echoed length always match
   assign echo_n = (stage_ff.resp_len > 5'(dnic_pkg::UID_BYTES)) ? 5'(dnic_pkg::UID_BYTES)
                                                                 : stage_ff.resp_len;
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < dnic_pkg::UID_BYTES; i++) begin
         if ((5'(i) < echo_n) && (echo_all[8*i +: 8] != uid_all[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   assign node_ok = (stage_ff.resp_node != 7'd0) &&
                    (stage_ff.resp_node <= 7'(dnic_pkg::MAX_NODE));

   always_comb begin
      allocated_in = allocated_ff;
      prefix_in    = prefix_ff;
      out_in       = '0;
      if (stage_ff.op == dnic_pkg::OP_REQUEST) begin
         if (prefix_ff < 5'(dnic_pkg::UID_BYTES)) begin
            out_in.req_valid  = 1'b1;
            out_in.req_first  = (prefix_ff == 5'd0);
            out_in.req_prefer = preferred_ff;
            out_in.req_len    = chunk;
            for (int k = 0; k < dnic_pkg::OUT_BYTES; k++) begin
               if (3'(k) < chunk) begin
                  out_in.req_bytes[8*k +: 8] = uid_shift[8*k +: 8];
               end
            end
         end
      end else if (allocated_ff == 7'd0 && match) begin
         if (node_ok) begin
            allocated_in = stage_ff.resp_node;
            prefix_in    = 5'd0;
         end else begin
            prefix_in = echo_n;
         end
      end
      out_in.held_id = allocated_in;
      out_in.echoed  = prefix_in;
   end

   // input stage, result stage and client state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         allocated_ff   <= '0;
         prefix_ff      <= '0;
      end else begin
         if (req_if.ready) begin
            stage_valid_ff <= req_if.valid;
         end
         if (out_free) begin
            out_valid_ff <= stage_valid_ff;
         end
         if (stage_move) begin
            allocated_ff <= allocated_in;
            prefix_ff    <= prefix_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         stage_ff <= req_if.data;
      end
      if (stage_move) begin
         out_ff <= out_in;
      end
   end

   `DNIC_ASSERT(a_held_clears_prefix, clock, reset, (allocated_ff != 7'd0) |-> (prefix_ff == 5'd0))
   `DNIC_ASSERT(a_prefix_in_range, clock, reset, prefix_ff <= 5'(dnic_pkg::UID_BYTES))
   `DNIC_ASSERT(a_held_id_sticks, clock, reset, (allocated_ff != 7'd0) |=> $stable(allocated_ff))
   `DNIC_ASSERT(a_chunk_not_empty, clock, reset, (out_valid_ff && out_ff.req_valid) |-> (out_ff.req_len != 3'd0))
   `DNIC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!out_valid_ff && !stage_valid_ff))

endmodule
